>>> design/dspk_pkg.sv
package dspk_pkg;

  localparam int MAX_CHANNELS_DEF = 128;
  localparam int COUNT_W          = 8;
  localparam int SAMPLE_W         = 16;

  localparam logic [SAMPLE_W-1:0] WORD_FLAG     = 16'h8000;
  localparam logic [SAMPLE_W-1:0] WORD_NEG_MARK = 16'h4000;
  localparam logic [SAMPLE_W-1:0] WORD_POS_MASK = 16'h3fff;
  localparam logic [SAMPLE_W-1:0] DELTA_POS_MAX = 16'd63;
  localparam logic [SAMPLE_W-1:0] DELTA_NEG_MIN = 16'hffc1;
  localparam logic [7:0]          BYTE_NEG_MASK = 8'h7f;
  localparam logic [7:0]          BYTE_POS_MASK = 8'h3f;

endpackage

>>> design/dspk_sample_ram.sv
module dspk_sample_ram #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // read-first: the old entry comes out while the new sample goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

>>> design/dspk_channel_seq.sv
module dspk_channel_seq #(
  parameter int MAX_CHANNELS = 128,
  parameter int ADDR_W       = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dspk_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                         advance,
  input  logic                         epoch_start,
  output logic [ADDR_W-1:0]            channel,
  output logic                         first_row_now
);

  import dspk_pkg::*;

  localparam int CW = (ADDR_W + 1 > COUNT_W + 1) ? ADDR_W + 1 : COUNT_W + 1;

  logic [COUNT_W-1:0] channel_count;
  logic [ADDR_W-1:0]  position;
  logic               first_row;
  logic [CW-1:0]      count_ext;
  logic [CW-1:0]      count_eff;
  logic [CW-1:0]      next_pos_ext;
  logic               wrap;

  always_comb begin
    channel       = epoch_start ? '0 : position;
    first_row_now = epoch_start | first_row;
    count_ext     = CW'(channel_count);
    if (count_ext == '0) begin
      count_eff = CW'(1);
    end else if (count_ext > CW'(MAX_CHANNELS)) begin
      count_eff = CW'(MAX_CHANNELS);
    end else begin
      count_eff = count_ext;
    end
    next_pos_ext = CW'(channel) + CW'(1);
    wrap         = next_pos_ext >= count_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      channel_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      first_row <= 1'b1;
    end else if (advance) begin
      if (wrap) begin
        position  <= '0;
        first_row <= 1'b0;
      end else begin
        position  <= next_pos_ext[ADDR_W-1:0];
        first_row <= first_row_now;
      end
    end
  end

endmodule

>>> design/multichannel_delta_sample_packer_core.sv
// a sample is registered in s1 with its stored predecessor, then its code at the output
// one sample per cycle while out_stall is low; memory is read and written once per sample
// consecutive samples of the same channel need no interlock (read-first memory)
// reset: synchronous, clears the pipeline, channel position 0, first row set, channel count 1
// previous samples are not cleared; the first row of an epoch writes them before use
module multichannel_delta_sample_packer_core #(
  parameter int MAX_CHANNELS = dspk_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dspk_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [dspk_pkg::SAMPLE_W-1:0] sample,
  input  logic                          epoch_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dspk_pkg::SAMPLE_W-1:0] code,
  output logic                          is_word
);

  import dspk_pkg::*;

  localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic                accept;
  logic [ADDR_W-1:0]   channel;
  logic                first_row_now;
  logic [SAMPLE_W-1:0] prev_sample;

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_first;
  logic                out_free;
  logic                s1_move;

  logic [SAMPLE_W-1:0] diff;
  logic                neg;
  logic                small_delta;
  logic                word;
  logic [SAMPLE_W-1:0] code_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  dspk_channel_seq #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .advance      (accept),
    .epoch_start  (epoch_start),
    .channel      (channel),
    .first_row_now(first_row_now)
  );

  dspk_sample_ram #(
    .DEPTH (MAX_CHANNELS),
    .ADDR_W(ADDR_W),
    .DATA_W(SAMPLE_W)
  ) u_ram (
    .clk  (clk),
    .en   (accept),
    .addr (channel),
    .wdata($unsigned(sample)),
    .rdata(prev_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= $unsigned(sample);
      s1_first  <= first_row_now;
    end
  end

  always_comb begin
    diff = s1_sample - prev_sample;
    neg  = diff[SAMPLE_W-1];
    // magnitude up to 63 in either direction fits in a delta byte
    small_delta = neg ? (diff >= DELTA_NEG_MIN) : (diff <= DELTA_POS_MAX);
    word        = s1_first || !small_delta;
    if (word) begin
      if (s1_sample[SAMPLE_W-1]) begin
        code_next = s1_sample | WORD_NEG_MARK;
      end else begin
        code_next = (s1_sample & WORD_POS_MASK) | WORD_FLAG;
      end
    end else begin
      code_next = {8'h00, diff[7:0] & (neg ? BYTE_NEG_MASK : BYTE_POS_MASK)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      code    <= code_next;
      is_word <= word;
    end
  end

endmodule

>>> bench/testbench.sv
module testbench;
  import dspk_pkg::*;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                start;
  } sample_item_t;

  typedef struct {
    logic [SAMPLE_W-1:0] code;
    logic                is_word;
  } packed_code_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                epoch_start = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] code;
  logic                is_word;

  multichannel_delta_sample_packer_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .epoch_start (epoch_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code        (code),
    .is_word     (is_word)
  );

  always #1 clk = ~clk;

  logic [COUNT_W-1:0] channels_reg = 8'd1;

  sample_item_t sample_fifo[$];
  packed_code_t expected_codes[$];
  int           fail_count = 0;

  // encoder state as the block should hold it
  logic [SAMPLE_W-1:0] last_sample [MAX_CHANNELS_DEF];
  int                  chan_pos = 0;
  bit                  first_row = 1'b1;

  // stimulus-side view of the same position, used to keep every read channel written
  logic [SAMPLE_W-1:0] gen_last [MAX_CHANNELS_DEF];
  bit                  gen_written [MAX_CHANNELS_DEF];
  int                  gen_pos = 0;
  bit                  gen_first = 1'b1;

  logic [SAMPLE_W-1:0] jump_steps [8] = '{16'h003f, 16'h0040, 16'hffc1, 16'hffc0,
                                          16'h0041, 16'hffbf, 16'h8000, 16'h7fff};

  int  send_gap = 0;
  bit  send_quiet = 1'b0;
  int  recv_hold = 0;
  bit  recv_quiet = 1'b0;

  function automatic int eff_count();
    if (int'(channels_reg) == 0) return 1;
    if (int'(channels_reg) > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
    return int'(channels_reg);
  endfunction

  function automatic void pack_sample(logic [SAMPLE_W-1:0] s, logic start);
    packed_code_t        r;
    logic [SAMPLE_W-1:0] diff;
    logic                neg;
    int                  mag;
    int                  ch;
    if (start) begin
      chan_pos  = 0;
      first_row = 1'b1;
    end
    ch   = chan_pos;
    diff = s - last_sample[ch];
    neg  = diff[SAMPLE_W-1];
    mag  = neg ? 65536 - int'(diff) : int'(diff);
    // first row never looks at the stored value
    r.is_word = first_row || (mag > int'(DELTA_POS_MAX));
    if (r.is_word) begin
      if (s[SAMPLE_W-1]) r.code = s | WORD_NEG_MARK;
      else r.code = (s & WORD_POS_MASK) | WORD_FLAG;
    end else begin
      r.code = {8'h00, diff[7:0] & (neg ? BYTE_NEG_MASK : BYTE_POS_MASK)};
    end
    last_sample[ch] = s;
    if (ch + 1 >= eff_count()) begin
      chan_pos  = 0;
      first_row = 1'b0;
    end else begin
      chan_pos = ch + 1;
    end
    expected_codes.push_back(r);
  endfunction

  function automatic void queue_sample(logic [SAMPLE_W-1:0] value, bit start);
    sample_item_t it;
    // a channel never written may only be reached in a first row
    if (!gen_first && !gen_written[gen_pos]) start = 1'b1;
    if (start) begin
      gen_pos   = 0;
      gen_first = 1'b1;
    end
    gen_written[gen_pos] = 1'b1;
    gen_last[gen_pos]    = value;
    if (gen_pos + 1 >= eff_count()) begin
      gen_pos   = 0;
      gen_first = 1'b0;
    end else begin
      gen_pos++;
    end
    it.value = value;
    it.start = start;
    sample_fifo.push_back(it);
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (sample_fifo.size() != 0 || in_valid || expected_codes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] v);
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= v;
    channels_reg  = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    sample_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap  = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) pack_sample(sample, epoch_start);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (sample_fifo.size() > 0) begin
        nxt = sample_fifo.pop_front();
        sample      <= nxt.value;
        epoch_start <= nxt.start;
        in_valid    <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    packed_code_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_hold  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          $error("code: unexpected transaction, got %h", code);
          fail_count++;
        end else begin
          want = expected_codes.pop_front();
          if (code !== want.code) begin
            $error("code: expected %h, got %h", want.code, code);
            fail_count++;
          end
          if (is_word !== want.is_word) begin
            $error("is_word: expected %b, got %b", want.is_word, is_word);
            fail_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
        recv_hold = recv_quiet ? 0 : $urandom_range(0, 12);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold != 0);
    end
  end

  initial begin
    int              n;
    int              eff;
    int              items;
    int              total;
    int              pick;
    int              ch;
    bit              ep;
    logic [SAMPLE_W-1:0] s;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // single channel: thresholds, wrap, negative and positive words
    queue_sample(16'h7fff, 1'b1);
    queue_sample(16'h8000, 1'b0);  // wraps to a delta of +1
    queue_sample(16'h803f, 1'b0);
    queue_sample(16'h8000, 1'b0);
    queue_sample(16'h8040, 1'b0);
    queue_sample(16'h0040, 1'b0);  // difference of -32768
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'hffff, 1'b0);
    queue_sample(16'h0000, 1'b1);  // epoch restart forces a word
    queue_sample(16'h4000, 1'b0);
    queue_sample(16'hc000, 1'b0);

    drain();
    write_count(8'd0);  // behaves as one channel
    queue_sample(16'hc001, 1'b0);
    queue_sample(16'hbfc1, 1'b0);

    drain();
    write_count(8'd3);
    queue_sample(16'h0100, 1'b1);
    queue_sample(16'hff00, 1'b0);
    queue_sample(16'h3fff, 1'b0);
    queue_sample(16'h0101, 1'b0);
    queue_sample(16'hfefe, 1'b0);

    // count lowered while sitting on the third channel
    drain();
    write_count(8'd1);
    queue_sample(16'h3ffe, 1'b0);
    queue_sample(16'h0102, 1'b0);

    drain();
    write_count(8'd255);
    queue_sample(16'h8001, 1'b1);
    queue_sample(16'h7ffe, 1'b0);
    queue_sample(16'h0000, 1'b0);

    total = 0;
    for (int ph = 0; total < 1200; ph++) begin
      case (ph)
        0: n = 128;
        1: n = 255;
        default: begin
          pick = $urandom_range(0, 19);
          case (pick)
            0: n = 0;
            1: n = 1;
            2: n = 2;
            3: n = $urandom_range(100, 255);
            default: n = $urandom_range(1, 12);
          endcase
        end
      endcase
      drain();
      write_count(n[COUNT_W-1:0]);
      eff = eff_count();
      if (ph == 0) items = 2 * eff + 5;
      else if (eff > 12) items = eff + $urandom_range(5, 40);
      else items = eff * $urandom_range(2, 6) + $urandom_range(0, eff - 1);
      repeat (items) begin
        ep = ($urandom_range(0, 39) == 0) ||
             (gen_pos == 0 && $urandom_range(0, 7) == 0);
        ch = ep ? 0 : gen_pos;
        pick = $urandom_range(0, 9);
        if (pick < 6) s = gen_last[ch] + 16'($urandom_range(0, 126) - 63);
        else if (pick < 8) s = gen_last[ch] + jump_steps[$urandom_range(0, 7)];
        else s = 16'($urandom);
        queue_sample(s, ep);
        total++;
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("** multichannel_delta_sample_packer_core: PASSED **");
    end else begin
      $display("** multichannel_delta_sample_packer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("** multichannel_delta_sample_packer_core: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
design/dspk_pkg.sv
design/dspk_sample_ram.sv
design/dspk_channel_seq.sv
design/multichannel_delta_sample_packer_core.sv
bench/testbench.sv
